FILE: design/hrhp_pkg.sv
package hrhp_pkg;

  localparam int CL_NAME_LEN = 14;

  typedef enum logic [2:0] {
    EV_METHOD  = 3'd0,
    EV_PATH    = 3'd1,
    EV_VERSION = 3'd2,
    EV_NAME    = 3'd3,
    EV_VALUE   = 3'd4,
    EV_DROPPED = 3'd5,
    EV_END     = 3'd6,
    EV_TOOLONG = 3'd7
  } event_kind_t;

  // one parsed result
  typedef struct packed {
    event_kind_t kind;
    logic [12:0] token_start;
    logic [13:0] token_length;
    logic [5:0]  header_index;
    logic [31:0] cl_value;
    logic [20:0] body_length;
    logic [12:0] dropped_count;
  } result_t;

  // one input byte with its start flag
  typedef struct packed {
    logic       new_request;
    logic [7:0] data_byte;
  } item_t;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_PLUS  = 8'h2b;

  function automatic logic [7:0] cl_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0: c = "C";
      4'd1: c = "o";
      4'd2: c = "n";
      4'd3: c = "t";
      4'd4: c = "e";
      4'd5: c = "n";
      4'd6: c = "t";
      4'd7: c = "-";
      4'd8: c = "L";
      4'd9: c = "e";
      4'd10: c = "n";
      4'd11: c = "g";
      4'd12: c = "t";
      4'd13: c = "h";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

endpackage

FILE: design/http_request_header_parser.sv
// HTTP request head parser.
// Each byte passes through the input queue, then the result register, before its result appears.
// Throughput: one byte per cycle while m_tready does not stall a held result, set by the parse engine step.
// Reset: synchronous, active high; clears parse state, queue and result register,
// and loads max_headers 32, max_header_bytes 8192, max_body_bytes 1048576.
module http_request_header_parser
  import hrhp_pkg::*;
#(
  parameter int HEAD_BUFFER_BYTES = 8192,
  parameter int HEADER_SLOTS      = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // data_byte
  input  logic         s_tuser,   // new_request
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // token_start, token_length, header_index,
                                  // cl_value, body_length, dropped_count
  output logic [2:0]   m_tuser,   // event_kind
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam logic [3:0] ADDR_MAX_HEADERS = 4'h0;
  localparam logic [3:0] ADDR_MAX_HDR_B   = 4'h4;
  localparam logic [3:0] ADDR_MAX_BODY    = 4'h8;

  logic [6:0]  max_headers;
  logic [13:0] max_header_bytes;
  logic [20:0] max_body_bytes;

  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_headers      <= 7'd32;
      max_header_bytes <= 14'd8192;
      max_body_bytes   <= 21'd1048576;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        ADDR_MAX_HEADERS: max_headers      <= pwdata[6:0];
        ADDR_MAX_HDR_B:   max_header_bytes <= pwdata[13:0];
        ADDR_MAX_BODY:    max_body_bytes   <= pwdata[20:0];
        default: begin
        end
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (paddr)
      ADDR_MAX_HEADERS: prdata = {25'd0, max_headers};
      ADDR_MAX_HDR_B:   prdata = {18'd0, max_header_bytes};
      ADDR_MAX_BODY:    prdata = {11'd0, max_body_bytes};
      default:          prdata = 32'd0;
    endcase
  end

  // front: input queue
  item_t q_item;
  logic  q_valid, q_ready;
  logic [8:0] q_data;

  hrhp_fifo #(.WIDTH(9)) u_fifo (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready), .in_data({s_tuser, s_tdata}),
    .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
  );
  assign q_item = item_t'(q_data);

  // back: parse engine
  result_t res;

  hrhp_engine #(
    .HEAD_BUFFER_BYTES(HEAD_BUFFER_BYTES), .HEADER_SLOTS(HEADER_SLOTS)
  ) u_engine (
    .clk(clk), .rst(rst),
    .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res),
    .max_headers(max_headers), .max_header_bytes(max_header_bytes),
    .max_body_bytes(max_body_bytes)
  );

  assign m_tuser = res.kind;
  assign m_tdata = {5'd0, res.dropped_count, res.body_length, res.cl_value,
                    res.header_index, res.token_length, res.token_start};

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // token fields are zero for non-token events
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == EV_DROPPED || m_tuser == EV_TOOLONG)
    |-> m_tdata[26:0] == 27'd0)
    else $error("token fields set on non-token event");

  // body length never exceeds content length at end
  a_body: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == EV_END |-> {11'd0, m_tdata[85:65]} <= m_tdata[64:33])
    else $error("body length above content length");

endmodule

FILE: design/hrhp_fifo.sv
module hrhp_fifo
  import hrhp_pkg::*;
#(
  parameter int WIDTH = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  // two-entry queue
  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: design/hrhp_engine.sv
module hrhp_engine
  import hrhp_pkg::*;
#(
  parameter int HEAD_BUFFER_BYTES = 8192,
  parameter int HEADER_SLOTS      = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  item_t       in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_res,
  input  logic [6:0]  max_headers,
  input  logic [13:0] max_header_bytes,
  input  logic [20:0] max_body_bytes
);

  typedef enum logic [2:0] {
    PH_METHOD  = 3'd0,
    PH_PATH    = 3'd1,
    PH_VERSION = 3'd2,
    PH_SKIP    = 3'd3,
    PH_NAME    = 3'd4,
    PH_VALUE   = 3'd5,
    PH_DONE    = 3'd6,
    PH_BLANKCR = 3'd7
  } phase_t;

  localparam logic [16:0] HB_LIM = 17'(HEAD_BUFFER_BYTES);
  localparam logic [8:0]  HS_LIM = 9'(HEADER_SLOTS);

  phase_t      phase;
  logic [13:0] byte_offset;
  logic        prev_was_cr, line_is_empty, seen_nonblank, name_match_ok;
  logic [12:0] first_pos, last_pos;
  logic [6:0]  kept_count;
  logic [12:0] dropped;
  logic [3:0]  match_pos;
  logic [31:0] acc, length_found;
  logic        cl_target, cl_live;
  logic        res_valid;
  result_t     res;

  // output register; accept while it is empty or drains
  logic take;
  assign in_ready  = !res_valid || out_ready;
  assign take      = in_valid && in_ready;
  assign out_valid = res_valid;
  assign out_res   = res;

  // effective limits
  logic [13:0] limit;
  logic [6:0]  kept_limit;
  assign limit = ({3'd0, max_header_bytes} < HB_LIM) ? max_header_bytes : HB_LIM[13:0];
  assign kept_limit = ({2'd0, max_headers} < HS_LIM) ? max_headers : HS_LIM[6:0];

  // digit step with saturation
  function automatic logic [31:0] acc_step(input logic [31:0] a, input logic [7:0] d);
    logic [35:0] v;
    v = {4'd0, a} * 36'd10 + {32'd0, d[3:0]};
    return (v > 36'hFFFFFFFF) ? 32'hFFFFFFFF : v[31:0];
  endfunction

  always_ff @(posedge clk) begin
    phase_t      ph;
    logic [13:0] off, prv;
    logic [7:0]  b;
    logic        blank, lie, sn, mok, tgt, live, pcr, emit;
    logic [12:0] fp, lp, drp;
    logic [3:0]  mp;
    logic [31:0] ac, lf;
    logic [6:0]  kc;
    logic        first;
    logic        rv;
    result_t     r;
    if (rst) begin
      phase <= PH_METHOD; byte_offset <= '0; prev_was_cr <= 1'b0;
      line_is_empty <= 1'b1; seen_nonblank <= 1'b0; first_pos <= '0;
      last_pos <= '0; kept_count <= '0; dropped <= '0; match_pos <= '0;
      name_match_ok <= 1'b1; acc <= '0; length_found <= '0;
      cl_target <= 1'b0; cl_live <= 1'b0; res_valid <= 1'b0;
    end else begin
      rv = res_valid && !out_ready;
      if (take) begin
        ph = phase; off = byte_offset; pcr = prev_was_cr; lie = line_is_empty;
        sn = seen_nonblank; fp = first_pos; lp = last_pos; kc = kept_count;
        drp = dropped; mp = match_pos; mok = name_match_ok; ac = acc;
        lf = length_found; tgt = cl_target; live = cl_live;
        b = in_item.data_byte; emit = 1'b0; r = '0;
        if (in_item.new_request) begin
          ph = PH_METHOD; off = '0; pcr = 1'b0; lie = 1'b1; sn = 1'b0;
          fp = '0; lp = '0; mp = '0; mok = 1'b1; kc = '0; drp = '0;
          ac = '0; lf = '0; tgt = 1'b0; live = 1'b0;
        end
        prv = (off != 14'd0) ? off - 14'd1 : 14'd0;
        blank = (b == CH_SPACE) || (b == CH_TAB);
        if (ph == PH_DONE) begin
          // ignored
        end else if (off >= limit) begin
          ph = PH_DONE; emit = 1'b1; r.kind = EV_TOOLONG;
        end else begin
          // held CR that turned out to be content
          if (ph == PH_BLANKCR && b != CH_LF) begin
            lie = 1'b0;
            if (!sn) begin fp = prv[12:0]; sn = 1'b1; end
            lp = prv[12:0];
            if (mp < 4'(CL_NAME_LEN)) begin
              if (CH_CR != cl_char(mp)) mok = 1'b0;
              mp = mp + 4'd1;
            end
            ph = PH_NAME;
          end else if (ph == PH_VALUE && pcr && b != CH_LF) begin
            first = !sn;
            if (!sn) begin fp = prv[12:0]; sn = 1'b1; end
            lp = prv[12:0];
            if (live && !(first && CH_CR == CH_PLUS)) live = 1'b0;
          end
          unique case (ph)
            PH_METHOD, PH_PATH: begin
              if (b == CH_SPACE) begin
                emit = 1'b1; r.kind = event_kind_t'(ph);
                r.token_start = fp; r.token_length = off - {1'b0, fp};
                ph = (ph == PH_METHOD) ? PH_PATH : PH_VERSION;
                fp = off[12:0] + 13'd1;
              end
            end
            PH_VERSION: begin
              if (b == CH_SPACE || b == CH_CR) begin
                emit = 1'b1; r.kind = EV_VERSION;
                r.token_start = fp; r.token_length = off - {1'b0, fp};
                ph = PH_SKIP;
              end
            end
            PH_SKIP: begin
              if (b == CH_LF && pcr) begin
                ph = PH_NAME; lie = 1'b1; sn = 1'b0; fp = '0; lp = '0;
                mp = '0; mok = 1'b1;
              end
            end
            PH_NAME: begin
              if (b == CH_COLON || (b == CH_CR && !lie)) begin
                if (kc < kept_limit) begin
                  emit = 1'b1; r.kind = EV_NAME;
                  r.token_start = sn ? fp : off[12:0];
                  r.token_length = sn ? {1'b0, lp - fp} + 14'd1 : 14'd0;
                  r.header_index = kc[5:0];
                end
                tgt = (kc < kept_limit) && mok && (mp >= 4'(CL_NAME_LEN));
                live = tgt; ac = '0; sn = 1'b0; fp = '0; lp = '0;
                ph = PH_VALUE;
              end else if (b == CH_CR) begin
                ph = PH_BLANKCR;
              end else begin
                lie = 1'b0;
                if (!blank) begin
                  if (!sn) begin fp = off[12:0]; sn = 1'b1; end
                  lp = off[12:0];
                end
                if (sn && mp < 4'(CL_NAME_LEN)) begin
                  if (b != cl_char(mp)) mok = 1'b0;
                  mp = mp + 4'd1;
                end
              end
            end
            PH_VALUE: begin
              if (b == CH_LF && pcr) begin
                emit = 1'b1;
                if (kc < kept_limit) begin
                  r.kind = EV_VALUE;
                  r.token_start = sn ? fp : prv[12:0];
                  r.token_length = sn ? {1'b0, lp - fp} + 14'd1 : 14'd0;
                  r.header_index = kc[5:0];
                  if (tgt) lf = ac;
                  kc = kc + 7'd1;
                end else begin
                  if (drp != 13'h1FFF) drp = drp + 13'd1;
                  r.kind = EV_DROPPED;
                end
                tgt = 1'b0; live = 1'b0; ph = PH_NAME;
                lie = 1'b1; sn = 1'b0; fp = '0; lp = '0; mp = '0; mok = 1'b1;
              end else if (b == CH_CR) begin
                // held for one byte
              end else if (blank) begin
                if (sn) live = 1'b0;
              end else begin
                first = !sn;
                if (!sn) begin fp = off[12:0]; sn = 1'b1; end
                lp = off[12:0];
                if (live && !(first && b == CH_PLUS)) begin
                  if (b >= "0" && b <= "9") ac = acc_step(ac, b);
                  else live = 1'b0;
                end
              end
            end
            PH_BLANKCR: begin
              ph = PH_DONE; emit = 1'b1; r.kind = EV_END;
              r.cl_value = lf;
              r.body_length = (lf < {11'd0, max_body_bytes}) ? lf[20:0] : max_body_bytes;
            end
            default: begin
            end
          endcase
          pcr = (b == CH_CR);
          if (off != 14'h3FFF) off = off + 14'd1;
        end
        r.dropped_count = drp;
        phase <= ph; byte_offset <= off; prev_was_cr <= pcr;
        line_is_empty <= lie; seen_nonblank <= sn; first_pos <= fp;
        last_pos <= lp; kept_count <= kc; dropped <= drp; match_pos <= mp;
        name_match_ok <= mok; acc <= ac; length_found <= lf;
        cl_target <= tgt; cl_live <= live;
        if (emit) begin
          rv = 1'b1;
          res <= r;
        end
      end
      res_valid <= rv;
    end
  end

endmodule
